FILE: hw/rtl/ptrb_pkg.sv
// ptrb_pkg: shared widths, constants and types for the range/bearing pipeline.
// No dependencies; imported by every ptrb_* module and the top level.
package ptrb_pkg;

  localparam int COORD_BITS        = 25;
  localparam int CORDIC_ITERATIONS = 24;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int ABS_BITS   = COORD_BITS;
  localparam int RANGE_BITS = 26;
  localparam int MILS_BITS  = 13;

  localparam logic [RANGE_BITS-1:0] RANGE_MAX   = '1;
  localparam logic [MILS_BITS-1:0]  MILS_CIRCLE = MILS_BITS'(6000);

  // square root: radicand and digit steps
  localparam int SQ_BITS    = 2 * RANGE_BITS + 1;
  localparam int SQRT_STEPS = (SQ_BITS + 1) / 2;

  // vectoring: operands normalized so the larger one reaches bit NORM_TOP
  localparam int NORM_TOP  = 52;
  localparam int SH_BITS   = $clog2(NORM_TOP + 1);
  localparam int CW_BITS   = NORM_TOP + 6;
  localparam int ZW_BITS   = 34;
  localparam int TABLE_LEN = 32;

  localparam int LOOP_STAGES = (SQRT_STEPS > CORDIC_ITERATIONS) ? SQRT_STEPS
                                                                : CORDIC_ITERATIONS;

  // binary angles, 2^ANGLE_FRAC per turn
  localparam int ANGLE_FRAC = 32;
  localparam int DW_BITS    = ANGLE_FRAC + 1;
  localparam int PROD_BITS  = DW_BITS + MILS_BITS;

  localparam int IN_TDATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((RANGE_BITS + MILS_BITS + 7) / 8) * 8;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam int ATAN_TURN [TABLE_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef enum logic [1:0] {
    Q_EAST,
    Q_NORTH,
    Q_WEST,
    Q_SOUTH
  } quad_t;

  typedef struct packed {
    quad_t quad;
    logic  a_zero;
    logic  b_zero;
    logic  sat;
  } ptrb_meta_t;

endpackage

FILE: hw/rtl/ptrb_front.sv
// ptrb_front: four stages - difference, magnitude/quadrant, squares and
// leading-one search, then sum of squares and normalizing shift. Uses ptrb_pkg.
module ptrb_front import ptrb_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] from_x,
  input  logic signed [COORD_BITS-1:0] from_y,
  input  logic signed [COORD_BITS-1:0] to_x,
  input  logic signed [COORD_BITS-1:0] to_y,
  output logic                         valid,
  output logic        [SQ_BITS-1:0]    sum_sq,
  output logic signed [CW_BITS-1:0]    x0,
  output logic signed [CW_BITS-1:0]    y0,
  output ptrb_meta_t                   meta
);

  localparam int STAGES = 4;

  logic [STAGES-1:0] v_r;

  logic signed [DIFF_BITS-1:0] dx_r, dy_r;

  logic signed [DIFF_BITS-1:0] dx_abs, dy_abs;
  logic [ABS_BITS-1:0]         a_nxt, b_nxt;
  logic                        dx_zero, dy_zero, dx_neg, dy_neg;
  ptrb_meta_t                  meta_nxt;
  logic [ABS_BITS-1:0]         a_r, b_r;
  ptrb_meta_t                  meta2_r;

  logic [RANGE_BITS-1:0]       a_t, b_t;
  logic [ABS_BITS-1:0]         or_ab;
  logic [SH_BITS-1:0]          msb;
  logic [2*RANGE_BITS-1:0]     asq_r, bsq_r;
  logic [ABS_BITS-1:0]         a3_r, b3_r;
  logic [SH_BITS-1:0]          sh_r;
  ptrb_meta_t                  meta3_r;

  logic [SQ_BITS-1:0]          sum_r;
  logic signed [CW_BITS-1:0]   x0_r, y0_r;
  ptrb_meta_t                  meta4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DIFF_BITS'(to_x) - DIFF_BITS'(from_x);
      dy_r <= DIFF_BITS'(to_y) - DIFF_BITS'(from_y);
    end
  end

  // stage 2
  always_comb begin
    dx_abs  = dx_r[DIFF_BITS-1] ? -dx_r : dx_r;
    dy_abs  = dy_r[DIFF_BITS-1] ? -dy_r : dy_r;
    a_nxt   = ABS_BITS'(dx_abs);
    b_nxt   = ABS_BITS'(dy_abs);
    dx_zero = (dx_r == '0);
    dy_zero = (dy_r == '0);
    dx_neg  = dx_r[DIFF_BITS-1];
    dy_neg  = dy_r[DIFF_BITS-1];
    if (!dx_neg && !dx_zero && !dy_neg) begin
      meta_nxt.quad = Q_EAST;
    end else if ((dx_neg || dx_zero) && !dy_neg && !dy_zero) begin
      meta_nxt.quad = Q_NORTH;
    end else if (dx_neg && (dy_neg || dy_zero)) begin
      meta_nxt.quad = Q_WEST;
    end else begin
      meta_nxt.quad = Q_SOUTH;
    end
    meta_nxt.a_zero = dx_zero;
    meta_nxt.b_zero = dy_zero;
    meta_nxt.sat    = (64'(a_nxt) > 64'(RANGE_MAX)) || (64'(b_nxt) > 64'(RANGE_MAX));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      meta2_r <= meta_nxt;
    end
  end

  // stage 3
  always_comb begin
    a_t   = RANGE_BITS'(a_r);
    b_t   = RANGE_BITS'(b_r);
    or_ab = a_r | b_r;
    msb   = '0;
    for (int i = 0; i < ABS_BITS; i++) begin
      if (or_ab[i]) begin
        msb = SH_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      asq_r   <= {{RANGE_BITS{1'b0}}, a_t} * {{RANGE_BITS{1'b0}}, a_t};
      bsq_r   <= {{RANGE_BITS{1'b0}}, b_t} * {{RANGE_BITS{1'b0}}, b_t};
      a3_r    <= a_r;
      b3_r    <= b_r;
      sh_r    <= SH_BITS'(NORM_TOP) - msb;
      meta3_r <= meta2_r;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= SQ_BITS'(asq_r) + SQ_BITS'(bsq_r);
      x0_r    <= CW_BITS'(a3_r) << sh_r;
      y0_r    <= CW_BITS'(b3_r) << sh_r;
      meta4_r <= meta3_r;
    end
  end

  assign valid  = v_r[STAGES-1];
  assign sum_sq = sum_r;
  assign x0     = x0_r;
  assign y0     = y0_r;
  assign meta   = meta4_r;

endmodule

FILE: hw/rtl/ptrb_sqrt.sv
// ptrb_sqrt: pipelined digit-by-digit integer square root, one root bit per stage,
// padded to LOOP_STAGES to stay aligned with the vectoring stages. Uses ptrb_pkg.
module ptrb_sqrt import ptrb_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_BITS-1:0] sum_sq,
  output logic [SQ_BITS-1:0] rem,
  output logic [SQ_BITS-1:0] root
);

  logic [SQ_BITS-1:0] s_r [LOOP_STAGES];
  logic [SQ_BITS-1:0] q_r [LOOP_STAGES];

  for (genvar k = 0; k < LOOP_STAGES; k++) begin : g_stage
    logic [SQ_BITS-1:0] s_in, q_in, s_nxt, q_nxt;

    if (k == 0) begin : g_first
      assign s_in = sum_sq;
      assign q_in = '0;
    end else begin : g_next
      assign s_in = s_r[k-1];
      assign q_in = q_r[k-1];
    end

    if (k < SQRT_STEPS) begin : g_step
      localparam logic [SQ_BITS-1:0] STEP_BIT = SQ_BITS'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_BITS-1:0] trial;
      always_comb begin
        trial = q_in + STEP_BIT;
        if (s_in >= trial) begin
          s_nxt = s_in - trial;
          q_nxt = (q_in >> 1) + STEP_BIT;
        end else begin
          s_nxt = s_in;
          q_nxt = q_in >> 1;
        end
      end
    end else begin : g_pass
      assign s_nxt = s_in;
      assign q_nxt = q_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= s_nxt;
        q_r[k] <= q_nxt;
      end
    end
  end

  assign rem  = s_r[LOOP_STAGES-1];
  assign root = q_r[LOOP_STAGES-1];

endmodule

FILE: hw/rtl/ptrb_cordic.sv
// ptrb_cordic: unrolled CORDIC vectoring pipeline, one rotation per stage; carries
// the valid bit and the quadrant/axis flags alongside. Uses ptrb_pkg.
module ptrb_cordic import ptrb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_in,
  input  logic signed [CW_BITS-1:0] x0,
  input  logic signed [CW_BITS-1:0] y0,
  input  ptrb_meta_t                meta_in,
  output logic                      valid,
  output logic signed [ZW_BITS-1:0] z,
  output ptrb_meta_t                meta
);

  logic [LOOP_STAGES-1:0]    v_r;
  logic signed [CW_BITS-1:0] x_r    [LOOP_STAGES];
  logic signed [CW_BITS-1:0] y_r    [LOOP_STAGES];
  logic signed [ZW_BITS-1:0] z_r    [LOOP_STAGES];
  ptrb_meta_t                meta_r [LOOP_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LOOP_STAGES-2:0], valid_in};
    end
  end

  for (genvar k = 0; k < LOOP_STAGES; k++) begin : g_stage
    logic signed [CW_BITS-1:0] x_in, y_in, x_nxt, y_nxt;
    logic signed [ZW_BITS-1:0] z_in, z_nxt;
    ptrb_meta_t                m_in;

    if (k == 0) begin : g_first
      assign x_in = x0;
      assign y_in = y0;
      assign z_in = '0;
      assign m_in = meta_in;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
      assign m_in = meta_r[k-1];
    end

    if (k < CORDIC_ITERATIONS) begin : g_rot
      localparam logic signed [ZW_BITS-1:0] STEP_ANGLE = ZW_BITS'(ATAN_TURN[k]);
      logic signed [CW_BITS-1:0] xs, ys;
      always_comb begin
        xs = x_in >>> k;
        ys = y_in >>> k;
        if (!y_in[CW_BITS-1]) begin
          x_nxt = x_in + ys;
          y_nxt = y_in - xs;
          z_nxt = z_in + STEP_ANGLE;
        end else begin
          x_nxt = x_in - ys;
          y_nxt = y_in + xs;
          z_nxt = z_in - STEP_ANGLE;
        end
      end
    end else begin : g_pass
      assign x_nxt = x_in;
      assign y_nxt = y_in;
      assign z_nxt = z_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        meta_r[k] <= m_in;
      end
    end
  end

  assign valid = v_r[LOOP_STAGES-1];
  assign z     = z_r[LOOP_STAGES-1];
  assign meta  = meta_r[LOOP_STAGES-1];

endmodule

FILE: hw/rtl/ptrb_back.sv
// ptrb_back: quadrant unfolding and range rounding, scaling to mils, then
// rounding, wrap and the output register. Uses ptrb_pkg.
module ptrb_back import ptrb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_in,
  input  logic signed [ZW_BITS-1:0] z,
  input  ptrb_meta_t                meta,
  input  logic [SQ_BITS-1:0]        rem,
  input  logic [SQ_BITS-1:0]        root,
  output logic                      out_valid,
  output logic [RANGE_BITS-1:0]     range_m,
  output logic [MILS_BITS-1:0]      bearing_mils,
  output logic                      same_point
);

  localparam logic [DW_BITS-1:0]   QUARTER = DW_BITS'(1) << (ANGLE_FRAC - 2);
  localparam logic [DW_BITS-1:0]   HALF    = DW_BITS'(1) << (ANGLE_FRAC - 1);
  localparam logic [DW_BITS-1:0]   FULL    = DW_BITS'(1) << ANGLE_FRAC;
  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (ANGLE_FRAC - 1);

  logic [2:0] v_r;

  logic [DW_BITS-1:0]    r_ang, dir_nxt;
  logic [SQ_BITS-1:0]    root_rnd;
  logic [RANGE_BITS-1:0] range_nxt;
  logic [DW_BITS-1:0]    dir_r;
  logic [RANGE_BITS-1:0] range1_r, range2_r;
  logic                  same1_r, same2_r;

  logic [PROD_BITS-1:0]   prod_r;
  logic [PROD_BITS-1:0]   prod_rnd;
  logic [MILS_BITS:0]     mils_raw;
  logic [MILS_BITS-1:0]   mils_nxt;

  logic [RANGE_BITS-1:0] range_r;
  logic [MILS_BITS-1:0]  bearing_r;
  logic                  same_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], valid_in};
    end
  end

  // stage 1: quadrant angle, full-circle direction, rounded range
  always_comb begin
    if (meta.b_zero) begin
      r_ang = '0;
    end else if (meta.a_zero) begin
      r_ang = QUARTER;
    end else if (z[ZW_BITS-1]) begin
      r_ang = '0;
    end else if ($unsigned(z) > ZW_BITS'(QUARTER)) begin
      r_ang = QUARTER;
    end else begin
      r_ang = DW_BITS'(z);
    end

    case (meta.quad)
      Q_EAST:  dir_nxt = r_ang;
      Q_NORTH: dir_nxt = HALF - r_ang;
      Q_WEST:  dir_nxt = HALF + r_ang;
      default: dir_nxt = FULL - r_ang;
    endcase

    root_rnd = root + SQ_BITS'(rem > root);
    if (meta.sat || (root_rnd > SQ_BITS'(RANGE_MAX))) begin
      range_nxt = RANGE_MAX;
    end else begin
      range_nxt = RANGE_BITS'(root_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r    <= dir_nxt;
      range1_r <= range_nxt;
      same1_r  <= meta.a_zero && meta.b_zero;
    end
  end

  // stage 2: scale to mils
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= PROD_BITS'(dir_r) * PROD_BITS'(MILS_CIRCLE);
      range2_r <= range1_r;
      same2_r  <= same1_r;
    end
  end

  // stage 3: round, wrap a full circle to zero, force coincident points
  always_comb begin
    prod_rnd = prod_r + ROUND_HALF;
    mils_raw = (MILS_BITS+1)'(prod_rnd >> ANGLE_FRAC);
    if (mils_raw >= (MILS_BITS+1)'(MILS_CIRCLE)) begin
      mils_nxt = MILS_BITS'(mils_raw - (MILS_BITS+1)'(MILS_CIRCLE));
    end else begin
      mils_nxt = MILS_BITS'(mils_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_r   <= same2_r ? '0 : range2_r;
      bearing_r <= same2_r ? '0 : mils_nxt;
      same_r    <= same2_r;
    end
  end

  assign out_valid    = v_r[2];
  assign range_m      = range_r;
  assign bearing_mils = bearing_r;
  assign same_point   = same_r;

endmodule

FILE: hw/rtl/points_to_range_and_bearing_mils.sv
// Range and bearing between two grid points: takes one point pair per cycle and
// returns the rounded distance in metres and the bearing from +X toward +Y in
// mils (6000 per circle), with a flag for coincident points. The pipeline is
// 4 + LOOP_STAGES + 3 stages deep; at the default widths LOOP_STAGES is set by
// the 27-step square root, one root bit per stage, with the 24 CORDIC rotations
// running alongside. Throughput is one pair per clock; when the result in the
// output register is not taken, the whole pipeline holds and in_tready drops in
// the same cycle.
// Depends on ptrb_pkg, ptrb_front, ptrb_sqrt, ptrb_cordic and ptrb_back.
module points_to_range_and_bearing_mils import ptrb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // from_x [24:0], from_y [49:25], to_x [74:50], to_y [99:75], zero pad above
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // range_m [25:0], bearing_mils [38:26], zero pad above
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  // same_point [0]
  output logic                      out_tuser
);

  logic en;

  logic                      f_valid;
  logic [SQ_BITS-1:0]        f_sum_sq;
  logic signed [CW_BITS-1:0] f_x0, f_y0;
  ptrb_meta_t                f_meta;

  logic [SQ_BITS-1:0]        s_rem, s_root;

  logic                      c_valid;
  logic signed [ZW_BITS-1:0] c_z;
  ptrb_meta_t                c_meta;

  logic [RANGE_BITS-1:0]     range_m;
  logic [MILS_BITS-1:0]      bearing_mils;
  logic                      same_point;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  ptrb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .from_x   (in_tdata[0*COORD_BITS +: COORD_BITS]),
    .from_y   (in_tdata[1*COORD_BITS +: COORD_BITS]),
    .to_x     (in_tdata[2*COORD_BITS +: COORD_BITS]),
    .to_y     (in_tdata[3*COORD_BITS +: COORD_BITS]),
    .valid    (f_valid),
    .sum_sq   (f_sum_sq),
    .x0       (f_x0),
    .y0       (f_y0),
    .meta     (f_meta)
  );

  ptrb_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .sum_sq (f_sum_sq),
    .rem    (s_rem),
    .root   (s_root)
  );

  ptrb_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (f_valid),
    .x0       (f_x0),
    .y0       (f_y0),
    .meta_in  (f_meta),
    .valid    (c_valid),
    .z        (c_z),
    .meta     (c_meta)
  );

  ptrb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .valid_in     (c_valid),
    .z            (c_z),
    .meta         (c_meta),
    .rem          (s_rem),
    .root         (s_root),
    .out_valid    (out_tvalid),
    .range_m      (range_m),
    .bearing_mils (bearing_mils),
    .same_point   (same_point)
  );

  assign out_tdata = OUT_TDATA_BITS'({bearing_mils, range_m});
  assign out_tuser = same_point;

  a_same_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[RANGE_BITS+MILS_BITS-1:0] == '0)
    else $error("coincident points must give zero range and bearing");

  a_bearing_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[RANGE_BITS +: MILS_BITS] < MILS_CIRCLE)
    else $error("bearing not wrapped below a full circle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

FILE: verif/points_to_range_and_bearing_mils_tb.sv
// Self-checking testbench for points_to_range_and_bearing_mils: streams point pairs,
// predicts rounded range and 6000-mil bearing per pair and checks every result.
// Depends on ptrb_pkg and the points_to_range_and_bearing_mils top level only.
`timescale 1ns / 1ps

module points_to_range_and_bearing_mils_tb;
  import ptrb_pkg::*;

  localparam int CMIN           = -(1 << (COORD_BITS - 1));
  localparam int CMAX           = (1 << (COORD_BITS - 1)) - 1;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 60;

  localparam longint ARC_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [RANGE_BITS-1:0] range_m;
    logic [MILS_BITS-1:0]  mils;
    logic                  same;
  } fix_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      out_tuser;

  fix_t        fix_q[$];
  fix_t        want;
  int          faults = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          coincident_seen = 0;
  int          burst_left = 8;
  int unsigned quiet_cycles = 0;
  bit          tx_gaps_on = 1'b0;
  bit          rx_stall_on = 1'b0;
  bit          rx_hold_req = 1'b0;

  points_to_range_and_bearing_mils dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned root_rounded(longint unsigned s);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 52;
    while (probe > s) probe >>= 2;
    while (probe != 0) begin
      if (s >= root + probe) begin
        s    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    if (s > root) root++;
    return root;
  endfunction

  // angle inside the first quadrant, 2^32 per turn
  function automatic longint quadrant_turn(longint a, longint b);
    longint x, y, z, xs, ys;
    if (b == 0) return 0;
    if (a == 0) return 64'sd1 << 30;
    while ((a | b) < (64'sd1 << 52)) begin
      a <<= 1;
      b <<= 1;
    end
    x = a;
    y = b;
    z = 0;
    for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += ARC_STEP[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ARC_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
    return z;
  endfunction

  function automatic fix_t predict_range_bearing(logic [IN_TDATA_BITS-1:0] d);
    coord_t          fx, fy, tx, ty;
    longint          dx, dy, a, b, qa, dir;
    longint unsigned rng, mils;
    quad_t           q;
    fix_t            f;
    fx = d[0*COORD_BITS +: COORD_BITS];
    fy = d[1*COORD_BITS +: COORD_BITS];
    tx = d[2*COORD_BITS +: COORD_BITS];
    ty = d[3*COORD_BITS +: COORD_BITS];
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    if (dx == 0 && dy == 0) begin
      f.range_m = '0;
      f.mils    = '0;
      f.same    = 1'b1;
      return f;
    end
    a = (dx < 0) ? -dx : dx;
    b = (dy < 0) ? -dy : dy;
    if (a > longint'(RANGE_MAX) || b > longint'(RANGE_MAX)) begin
      rng = RANGE_MAX;
    end else begin
      rng = root_rounded(a * a + b * b);
      if (rng > RANGE_MAX) rng = RANGE_MAX;
    end
    qa = quadrant_turn(a, b);
    if (dx > 0 && dy >= 0)      q = Q_EAST;
    else if (dx <= 0 && dy > 0) q = Q_NORTH;
    else if (dx < 0 && dy <= 0) q = Q_WEST;
    else                        q = Q_SOUTH;
    case (q)
      Q_EAST:  dir = qa;
      Q_NORTH: dir = (64'sd1 << 31) - qa;
      Q_WEST:  dir = (64'sd1 << 31) + qa;
      default: dir = (64'sd1 << 32) - qa;
    endcase
    mils = (longint'(dir) * 6000 + (64'sd1 << 31)) >> 32;
    if (mils >= 6000) mils -= 6000;
    f.range_m = rng[RANGE_BITS-1:0];
    f.mils    = mils[MILS_BITS-1:0];
    f.same    = 1'b0;
    return f;
  endfunction

  // ---------------------------------------------------------------- monitors

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      fix_q.push_back(predict_range_bearing(in_tdata));
      if (fix_q[$].same) coincident_seen++;
    end
  end

  task automatic report_fault(string what, longint unsigned exp_v, longint unsigned act_v);
    faults++;
    if (faults <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (fix_q.size() == 0) begin
        report_fault("unexpected transaction (count pending)", 0, 1);
      end else begin
        want = fix_q.pop_front();
        if (out_tdata[RANGE_BITS-1:0] != want.range_m)
          report_fault("range_m", want.range_m, out_tdata[RANGE_BITS-1:0]);
        if (out_tdata[RANGE_BITS +: MILS_BITS] != want.mils)
          report_fault("bearing_mils", want.mils, out_tdata[RANGE_BITS +: MILS_BITS]);
        if (out_tuser != want.same)
          report_fault("same_point", want.same, out_tuser);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t no transaction for %0d cycles, %0d results pending",
                 $realtime, QUIET_LIMIT, fix_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_stall_on) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_pair(input coord_t fx, input coord_t fy,
                           input coord_t tx, input coord_t ty);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_BITS'({ty, tx, fy, fx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (tx_gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  // keeps room for a small offset without leaving the coordinate range
  function automatic coord_t inner_coord();
    return coord_t'(int'($urandom_range(0, (1 << COORD_BITS) - 65)) + CMIN + 32);
  endfunction

  function automatic coord_t nudge(coord_t c, int span);
    return coord_t'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 3))
      0:       return coord_t'(CMIN);
      1:       return coord_t'(CMAX);
      2:       return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_geometry();
    send_pair(0, 0, 0, 0);
    send_pair(CMAX, CMIN, CMAX, CMIN);
    send_pair(0, 0, 100, 0);
    send_pair(0, 0, 0, 100);
    send_pair(0, 0, -100, 0);
    send_pair(0, 0, 0, -100);
    send_pair(CMIN, CMIN, CMAX, CMAX);
    send_pair(CMAX, CMAX, CMIN, CMIN);
    send_pair(CMIN, CMAX, CMAX, CMIN);
    send_pair(CMAX, CMIN, CMIN, CMAX);
    send_pair(CMIN, 0, CMAX, -1);
    send_pair(CMIN, 0, CMAX, 1);
    send_pair(0, CMIN, -1, CMAX);
    send_pair(CMIN, CMIN, CMIN, CMIN + 1);
    send_pair(1, 1, 0, 0);
    send_pair(0, 0, 1, 2);
    send_pair(0, 0, 3, 4);
    send_pair(CMAX, 0, CMIN, 0);
    send_pair(0, CMAX, 0, CMIN);
    send_pair(0, 0, CMAX, CMAX);
    send_pair(-1, -1, CMAX, 0);
  endtask

  task automatic test_random_wide(int n);
    repeat (n) send_pair(any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  task automatic test_random_close(int n);
    coord_t fx, fy;
    repeat (n) begin
      fx = inner_coord();
      fy = inner_coord();
      case ($urandom_range(0, 5))
        0:       send_pair(fx, fy, fx, fy);
        1:       send_pair(fx, fy, fx, nudge(fy, 6));
        2:       send_pair(fx, fy, nudge(fx, 6), fy);
        default: send_pair(fx, fy, nudge(fx, 6), nudge(fy, 6));
      endcase
    end
  endtask

  task automatic test_backpressure(int n);
    rx_hold_req = 1'b1;
    repeat (n) send_pair(any_coord(), any_coord(), inner_coord(), inner_coord());
  endtask

  task automatic test_random_mixed(int n);
    coord_t fx, fy;
    repeat (n) begin
      fx = inner_coord();
      fy = inner_coord();
      case ($urandom_range(0, 4))
        0: send_pair(any_coord(), any_coord(), any_coord(), any_coord());
        1: send_pair(fx, fy, nudge(fx, 3), nudge(fy, 3));
        2: send_pair(fx, fy, any_coord(), nudge(fy, 3));
        3: send_pair(fx, fy, nudge(fx, 3), any_coord());
        default: send_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord());
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_geometry();
    test_random_wide(200);
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_random_close(150);
    tx_gaps_on  = 1'b0;
    test_backpressure(120);
    tx_gaps_on  = 1'b1;
    test_random_mixed(220);

    in_tvalid <= 1'b0;
    while (fix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fix_q.size() != 0) report_fault("results left pending", 0, fix_q.size());

    $display("Sent %0d point pairs: axis, coincident, wrap and extreme cases, wide, close",
             items_sent);
    $display("and near-axis random pairs, %0d-cycle output hold; %0d results, %0d coincident.",
             RX_HOLD_CYCLES, results_seen, coincident_seen);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total", faults);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
